// ===== rtl/drt_pkg.sv =====
// shared types and constants for the dirty rectangle tracker
`default_nettype none
package drt_pkg;
    localparam int LIST_DEPTH_DEF = 32;
    localparam int COORD_BITS_DEF = 11;
    localparam int CFG_BITS       = 12;
    localparam int IN_BITS        = 16;
    localparam int OUT_BITS       = 11;

    localparam logic [1:0] CMD_INVALIDATE = 2'd0;
    localparam logic [1:0] CMD_CLEAR      = 2'd1;
    localparam logic [1:0] CMD_REFRESH    = 2'd2;

    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 12'd240;
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 12'd320;

    typedef struct packed {
        logic [1:0]          command;
        logic signed [15:0]  left;
        logic signed [15:0]  top;
        logic signed [15:0]  right;
        logic signed [15:0]  bottom;
    } in_word_t;

    typedef struct packed {
        logic [10:0] area_left;
        logic [10:0] area_top;
        logic [10:0] area_right;
        logic [10:0] area_bottom;
        logic        last_rect;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic latch_in;     // capture input word and clip
        logic scan_rd;      // issue read of scan index
        logic contain_chk;  // compare clipped box with read entry
        logic append;       // write clipped box at count
        logic collapse;     // write screen box at 0, count 1
        logic clear;        // empty list and marks
        logic ld_a;         // read entry a into accumulator
        logic pair_chk;     // test entry b against accumulator
        logic wb_a;         // write accumulator back to a
        logic emit_rd;      // read entry for emit
        logic emit_ld;      // load output register
    } drt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clip_empty;
        logic contained;
        logic full;
        logic mark_a;
        logic mark_b;
        logic is_last;
    } drt_stat_t;
endpackage
`default_nettype wire

// ===== rtl/drt_datapath.sv =====
// datapath: rectangle store, clipping, containment and merge arithmetic
`default_nettype none
module drt_datapath #(
    parameter int LIST_DEPTH = drt_pkg::LIST_DEPTH_DEF,
    parameter int IDX_BITS   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  drt_pkg::in_word_t             in_word,
    input  wire [drt_pkg::CFG_BITS-1:0]   screen_width,
    input  wire [drt_pkg::CFG_BITS-1:0]   screen_height,
    input  drt_pkg::drt_cmd_t             cmd,
    input  wire [IDX_BITS-1:0]            idx_a,
    input  wire [IDX_BITS-1:0]            idx_b,
    input  wire [IDX_BITS:0]              last_idx,
    output logic [IDX_BITS:0]             count,
    output drt_pkg::drt_stat_t            stat,
    output drt_pkg::out_word_t            out_word
);
    import drt_pkg::*;

    localparam int COORD_BITS = COORD_BITS_DEF;
    localparam int CB = COORD_BITS + 1;          // coordinate width plus one extension bit
    localparam int AB = 2 * CB + 1;              // area width
    localparam logic [CFG_BITS-1:0] MAX_DIM = CFG_BITS'(1 << COORD_BITS);

    typedef struct packed {
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
        logic [COORD_BITS-1:0] x2;
        logic [COORD_BITS-1:0] y2;
    } box_t;

    box_t mem [LIST_DEPTH];
    box_t rd_reg;
    box_t clip_reg, clip_next;
    logic clip_empty_reg, clip_empty_next;
    box_t acc_reg;
    logic [LIST_DEPTH-1:0] marks_reg;
    logic [IDX_BITS:0] count_reg;
    out_word_t out_reg;

    // clip
    logic [CFG_BITS-1:0] w_eff, h_eff;
    logic signed [IN_BITS:0] sx2, sy2, cl, ct, cr, cb;
    always_comb begin
        w_eff = (screen_width > MAX_DIM) ? MAX_DIM : screen_width;
        h_eff = (screen_height > MAX_DIM) ? MAX_DIM : screen_height;
        sx2 = $signed({5'd0, w_eff}) - 17'sd1;
        sy2 = $signed({5'd0, h_eff}) - 17'sd1;
        cl = (in_word.left > 16'sd0) ? 17'(in_word.left) : 17'sd0;
        ct = (in_word.top > 16'sd0) ? 17'(in_word.top) : 17'sd0;
        cr = (17'(in_word.right) < sx2) ? 17'(in_word.right) : sx2;
        cb = (17'(in_word.bottom) < sy2) ? 17'(in_word.bottom) : sy2;
        clip_empty_next = (cl > cr) || (ct > cb);
        clip_next.x1 = cl[COORD_BITS-1:0];
        clip_next.y1 = ct[COORD_BITS-1:0];
        clip_next.x2 = cr[COORD_BITS-1:0];
        clip_next.y2 = cb[COORD_BITS-1:0];
    end

    box_t scr;
    always_comb begin
        scr.x1 = '0;
        scr.y1 = '0;
        scr.x2 = sx2[COORD_BITS-1:0];
        scr.y2 = sy2[COORD_BITS-1:0];
    end

    // merge test
    box_t jb;
    logic ovl, take;
    logic [AB-1:0] ar_a, ar_b, ar_j;
    function automatic logic [AB-1:0] area(input box_t b);
        logic [CB-1:0] dx, dy;
        dx = {1'b0, b.x2} - {1'b0, b.x1} + CB'(1);
        dy = {1'b0, b.y2} - {1'b0, b.y1} + CB'(1);
        return AB'(dx) * AB'(dy);
    endfunction
    always_comb begin
        ovl = acc_reg.x1 <= rd_reg.x2 && acc_reg.x2 >= rd_reg.x1 &&
              acc_reg.y1 <= rd_reg.y2 && acc_reg.y2 >= rd_reg.y1;
        jb.x1 = (acc_reg.x1 < rd_reg.x1) ? acc_reg.x1 : rd_reg.x1;
        jb.y1 = (acc_reg.y1 < rd_reg.y1) ? acc_reg.y1 : rd_reg.y1;
        jb.x2 = (acc_reg.x2 > rd_reg.x2) ? acc_reg.x2 : rd_reg.x2;
        jb.y2 = (acc_reg.y2 > rd_reg.y2) ? acc_reg.y2 : rd_reg.y2;
        ar_a = area(acc_reg);
        ar_b = area(rd_reg);
        ar_j = area(jb);
        take = ovl && ({1'b0, ar_j} < ({1'b0, ar_a} + {1'b0, ar_b}));
    end

    // store
    always_ff @(posedge aclk) begin
        if (cmd.scan_rd || cmd.ld_a || cmd.pair_chk || cmd.emit_rd) begin
            rd_reg <= mem[idx_b];
        end
        if (cmd.append) begin
            mem[count_reg[IDX_BITS-1:0]] <= clip_reg;
        end else if (cmd.collapse) begin
            mem[0] <= scr;
        end else if (cmd.wb_a) begin
            mem[idx_a] <= acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            clip_reg <= clip_next;
            clip_empty_reg <= clip_empty_next;
        end
        if (cmd.ld_a) begin
            acc_reg <= rd_reg;
        end else if (cmd.pair_chk && take) begin
            acc_reg <= jb;
        end
        if (cmd.emit_ld) begin
            out_reg.area_left   <= OUT_BITS'(rd_reg.x1);
            out_reg.area_top    <= OUT_BITS'(rd_reg.y1);
            out_reg.area_right  <= OUT_BITS'(rd_reg.x2);
            out_reg.area_bottom <= OUT_BITS'(rd_reg.y2);
            out_reg.last_rect   <= ({1'b0, idx_b} == last_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            count_reg <= '0;
            marks_reg <= '0;
        end else begin
            if (cmd.append) begin
                count_reg <= count_reg + 1'b1;
            end else if (cmd.collapse) begin
                count_reg <= (IDX_BITS+1)'(1);
            end
            if (cmd.pair_chk && take) begin
                marks_reg[idx_b] <= 1'b1;
            end
        end
    end

    logic cont;
    always_comb begin
        cont = clip_reg.x1 >= rd_reg.x1 && clip_reg.y1 >= rd_reg.y1 &&
               clip_reg.x2 <= rd_reg.x2 && clip_reg.y2 <= rd_reg.y2;
        stat.clip_empty = clip_empty_reg;
        stat.contained  = cmd.contain_chk && cont;
        stat.full       = (count_reg == (IDX_BITS+1)'(LIST_DEPTH));
        stat.mark_a     = marks_reg[idx_a];
        stat.mark_b     = marks_reg[idx_b];
        stat.is_last    = ({1'b0, idx_b} == last_idx);
    end

    assign count    = count_reg;
    assign out_word = out_reg;
endmodule
`default_nettype wire

// ===== rtl/drt_controller.sv =====
// controller: sequences scan, merge and emit passes over the list
`default_nettype none
module drt_controller #(
    parameter int LIST_DEPTH = drt_pkg::LIST_DEPTH_DEF,
    parameter int IDX_BITS   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire [1:0]            command,
    output logic                 m_valid,
    input  wire                  m_ready,
    input  drt_pkg::drt_stat_t   stat,
    input  wire [IDX_BITS:0]     count,
    output drt_pkg::drt_cmd_t    cmd,
    output logic [IDX_BITS-1:0]  idx_a,
    output logic [IDX_BITS-1:0]  idx_b,
    output logic [IDX_BITS:0]    last_idx
);
    import drt_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_INV    = 4'd1;
    localparam logic [3:0] ST_SCAN   = 4'd2;
    localparam logic [3:0] ST_CHK    = 4'd3;
    localparam logic [3:0] ST_MA     = 4'd4;
    localparam logic [3:0] ST_MA_LD  = 4'd5;
    localparam logic [3:0] ST_MB     = 4'd6;
    localparam logic [3:0] ST_MB_CHK = 4'd7;
    localparam logic [3:0] ST_LAST   = 4'd8;
    localparam logic [3:0] ST_EM     = 4'd9;
    localparam logic [3:0] ST_EM_LD  = 4'd10;
    localparam logic [3:0] ST_EM_OUT = 4'd11;
    localparam logic [3:0] ST_WB     = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [IDX_BITS:0] a_reg, a_next, b_reg, b_next, last_reg, last_next;
    logic mv_reg, mv_next;

    assign idx_a    = a_reg[IDX_BITS-1:0];
    assign idx_b    = b_reg[IDX_BITS-1:0];
    assign last_idx = last_reg;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = mv_reg;

    always_comb begin
        state_next = state_reg;
        a_next = a_reg;
        b_next = b_reg;
        last_next = last_reg;
        mv_next = mv_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (command == CMD_INVALIDATE) begin
                        cmd.latch_in = 1'b1;
                        b_next = '0;
                        state_next = ST_INV;
                    end else if (command == CMD_CLEAR) begin
                        cmd.clear = 1'b1;
                    end else if (command == CMD_REFRESH && count != '0) begin
                        a_next = '0;
                        b_next = '0;
                        state_next = ST_MA;
                    end
                end
            end
            ST_INV: begin
                if (stat.clip_empty) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (b_reg == count) begin
                    if (stat.full) cmd.collapse = 1'b1;
                    else cmd.append = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cmd.scan_rd = 1'b1;
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                cmd.contain_chk = 1'b1;
                b_next = b_reg + 1'b1;
                state_next = stat.contained ? ST_IDLE : ST_SCAN;
            end
            ST_MA: begin
                b_next = a_reg;
                if (a_reg == count) begin
                    b_next = count - 1'b1;
                    state_next = ST_LAST;
                end else if (stat.mark_a) begin
                    a_next = a_reg + 1'b1;
                    b_next = a_reg + 1'b1;
                end else begin
                    cmd.scan_rd = 1'b1;
                    state_next = ST_MA_LD;
                end
            end
            ST_MA_LD: begin
                cmd.ld_a = 1'b1;
                b_next = '0;
                state_next = ST_MB;
            end
            ST_MB: begin
                if (b_reg == count) begin
                    state_next = ST_WB;
                end else if (stat.mark_b || b_reg == a_reg) begin
                    b_next = b_reg + 1'b1;
                end else begin
                    cmd.scan_rd = 1'b1;
                    state_next = ST_MB_CHK;
                end
            end
            ST_MB_CHK: begin
                cmd.pair_chk = 1'b1;
                b_next = b_reg + 1'b1;
                state_next = ST_MB;
            end
            ST_WB: begin
                cmd.wb_a = 1'b1;
                a_next = a_reg + 1'b1;
                b_next = a_reg + 1'b1;
                state_next = ST_MA;
            end
            ST_LAST: begin
                if (!stat.mark_b) begin
                    last_next = b_reg;
                    b_next = '0;
                    state_next = ST_EM;
                end else begin
                    b_next = b_reg - 1'b1;
                end
            end
            ST_EM: begin
                if (b_reg == count) begin
                    cmd.clear = 1'b1;
                    state_next = ST_IDLE;
                end else if (stat.mark_b) begin
                    b_next = b_reg + 1'b1;
                end else begin
                    cmd.emit_rd = 1'b1;
                    state_next = ST_EM_LD;
                end
            end
            ST_EM_LD: begin
                if (!mv_reg || m_ready) begin
                    cmd.emit_ld = 1'b1;
                    mv_next = 1'b1;
                    b_next = b_reg + 1'b1;
                    state_next = ST_EM;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (mv_reg && m_ready && !cmd.emit_ld) mv_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg <= 1'b0;
            a_reg <= '0;
            b_reg <= '0;
            last_reg <= '0;
        end else begin
            state_reg <= state_next;
            mv_reg <= mv_next;
            a_reg <= a_next;
            b_reg <= b_next;
            last_reg <= last_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/dirty_rectangle_tracker_core.sv =====
// top level of the dirty rectangle tracker
// channel | ports                      | word
// input   | s_valid s_ready s_data     | command and rectangle
// result  | m_valid m_ready m_data     | emitted rectangle, last flag
// config  | cfg_valid cfg_ready cfg_*  | register index and value
// invalidate: clip, then scan each stored rectangle for containment through the single memory read port
// refresh: one pass over all entries per unmarked entry, then emit
// clear and other commands are handled in the idle state
// reset is synchronous, no clearing pass; result stalls hold the emit loop
`default_nettype none
module dirty_rectangle_tracker_core #(
    parameter int LIST_DEPTH = drt_pkg::LIST_DEPTH_DEF
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         s_valid,
    output logic                        s_ready,
    input  drt_pkg::in_word_t           s_data,
    output logic                        m_valid,
    input  wire                         m_ready,
    output drt_pkg::out_word_t          m_data,
    input  wire                         cfg_valid,
    output logic                        cfg_ready,
    input  wire                         cfg_index,
    input  wire [drt_pkg::CFG_BITS-1:0] cfg_data
);
    import drt_pkg::*;

    localparam int IDX_BITS = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    logic [CFG_BITS-1:0] width_reg, height_reg;
    drt_cmd_t cmd;
    drt_stat_t stat;
    logic [IDX_BITS-1:0] idx_a, idx_b;
    logic [IDX_BITS:0] last_idx, count;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    drt_controller #(.LIST_DEPTH(LIST_DEPTH), .IDX_BITS(IDX_BITS)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .command(s_data.command),
        .m_valid, .m_ready, .stat, .count, .cmd, .idx_a, .idx_b, .last_idx
    );

    drt_datapath #(.LIST_DEPTH(LIST_DEPTH), .IDX_BITS(IDX_BITS)) u_dp (
        .aclk, .aresetn, .in_word(s_data), .screen_width(width_reg),
        .screen_height(height_reg), .cmd, .idx_a, .idx_b, .last_idx,
        .count, .stat, .out_word(m_data)
    );

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count <= (IDX_BITS+1)'(LIST_DEPTH)) else $error("count overflow");
    a_busy_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_ld |=> m_valid) else $error("emit lost");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pair_chk |-> !s_ready) else $error("accept during merge");
`endif
endmodule
`default_nettype wire
